// ----- hw/rtl/cna_pkg.sv -----
// Shared types, constants and helpers of the complex arithmetic unit.
package cna_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  // Quotient bits produced by the division chain; one chain cell per bit.
  localparam int unsigned QB = 34;
  // Width of the division remainder: a 64-bit magnitude shifted by up to QB.
  localparam int unsigned RW = 64 + QB;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_MOD  = 3'd4,
    CMD_CONJ = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [31:0]   res_re;
    logic [31:0]   res_im;
    logic          ov;
    logic          ovf_re;
    logic          ovf_im;
    logic          neg_re;
    logic          neg_im;
    logic [63:0]   den;
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [63:0]   sx;
    logic [63:0]   sr;
    logic [63:0]   sbit;
  } cell_t;

  // Saturates to 32 bits; bit 32 of the result is the overflow flag.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cna_cell.sv -----
// One chain cell: a restoring division step on both lanes and a square-root step.
module cna_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cna_pkg::cell_t data_i,
  output logic          valid_o,
  output cna_pkg::cell_t data_o
);

  logic           valid_q;
  cna_pkg::cell_t data_q, data_d;
  logic [63:0]    strial;

  always_comb begin
    data_d = data_i;
    strial = data_i.sr + data_i.sbit;
    if (data_i.dsh <= data_i.rem_re) begin
      data_d.rem_re = data_i.rem_re - data_i.dsh;
      data_d.q_re   = {data_i.q_re[cna_pkg::QB-2:0], 1'b1};
    end else begin
      data_d.q_re   = {data_i.q_re[cna_pkg::QB-2:0], 1'b0};
    end
    if (data_i.dsh <= data_i.rem_im) begin
      data_d.rem_im = data_i.rem_im - data_i.dsh;
      data_d.q_im   = {data_i.q_im[cna_pkg::QB-2:0], 1'b1};
    end else begin
      data_d.q_im   = {data_i.q_im[cna_pkg::QB-2:0], 1'b0};
    end
    data_d.dsh = data_i.dsh >> 1;
    // The root step runs only while its bit weight is nonzero.
    if (data_i.sbit != 64'd0) begin
      if (data_i.sx >= strial) begin
        data_d.sx = data_i.sx - strial;
        data_d.sr = (data_i.sr >> 1) + data_i.sbit;
      end else begin
        data_d.sr = data_i.sr >> 1;
      end
      data_d.sbit = data_i.sbit >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/cna_front.sv -----
// Front end: product stage and preparation stage that loads the first chain cell.
module cna_front #(
  parameter int unsigned FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               valid_o,
  output cna_pkg::cell_t     data_o
);

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic               v1_q, v2_q;
  logic [2:0]         cmd1_q;
  logic signed [31:0] a_q, b_q, c_q, d_q;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [31:0] sq0, sq1;
  cna_pkg::cell_t     data_q, data_d;

  logic signed [65:0] mre, mim, tr, ti, ntr, nti;
  logic signed [65:0] sum_re, sum_im;
  logic [63:0]        mag_re, mag_im, den;
  logic [cna_pkg::RW-1:0] num_re, num_im, lim;
  logic [32:0]        s_re, s_im;

  // For modulus the two squaring multipliers take the first operand instead.
  always_comb begin
    if (cmd_i == cna_pkg::CMD_MOD) begin
      sq0 = a_re_i;
      sq1 = a_im_i;
    end else begin
      sq0 = b_re_i;
      sq1 = b_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= cmd_i;
      a_q    <= a_re_i;
      b_q    <= a_im_i;
      c_q    <= b_re_i;
      d_q    <= b_im_i;
      p0_q   <= 64'(a_re_i) * 64'(b_re_i);
      p1_q   <= 64'(a_im_i) * 64'(b_im_i);
      p2_q   <= 64'(a_re_i) * 64'(b_im_i);
      p3_q   <= 64'(a_im_i) * 64'(b_re_i);
      p4_q   <= 64'(sq0) * 64'(sq0);
      p5_q   <= 64'(sq1) * 64'(sq1);
      data_q <= data_d;
    end
  end

  always_comb begin
    mre = (66'(p0_q) - 66'(p1_q) + HALF) >>> FRAC_BITS;
    mim = (66'(p2_q) + 66'(p3_q) + HALF) >>> FRAC_BITS;
    tr  = 66'(p0_q) + 66'(p1_q);
    ti  = 66'(p3_q) - 66'(p2_q);
    ntr = -tr;
    nti = -ti;
    mag_re = tr[65] ? ntr[63:0] : tr[63:0];
    mag_im = ti[65] ? nti[63:0] : ti[63:0];
    den    = p4_q[63:0] + p5_q[63:0];
    num_re = cna_pkg::RW'(mag_re) << FRAC_BITS;
    num_im = cna_pkg::RW'(mag_im) << FRAC_BITS;
    lim    = cna_pkg::RW'(den) << cna_pkg::QB;

    sum_re = 66'sd0;
    sum_im = 66'sd0;
    unique case (cmd1_q)
      cna_pkg::CMD_ADD: begin
        sum_re = 66'(a_q) + 66'(c_q);
        sum_im = 66'(b_q) + 66'(d_q);
      end
      cna_pkg::CMD_SUB: begin
        sum_re = 66'(a_q) - 66'(c_q);
        sum_im = 66'(b_q) - 66'(d_q);
      end
      cna_pkg::CMD_MUL: begin
        sum_re = mre;
        sum_im = mim;
      end
      cna_pkg::CMD_CONJ: begin
        sum_re = 66'(a_q);
        sum_im = -66'(b_q);
      end
      default: begin
        sum_re = 66'sd0;
        sum_im = 66'sd0;
      end
    endcase
    s_re = cna_pkg::sat32(sum_re);
    s_im = cna_pkg::sat32(sum_im);

    data_d        = '0;
    data_d.cmd    = cmd1_q;
    data_d.res_re = s_re[31:0];
    data_d.res_im = s_im[31:0];
    data_d.ov     = s_re[32] | s_im[32];
    data_d.ovf_re = num_re >= lim;
    data_d.ovf_im = num_im >= lim;
    data_d.neg_re = tr[65];
    data_d.neg_im = ti[65];
    data_d.den    = den;
    data_d.dsh    = cna_pkg::RW'(den) << (cna_pkg::QB - 1);
    data_d.rem_re = num_re;
    data_d.rem_im = num_im;
    data_d.sx     = den;
    data_d.sr     = 64'd0;
    data_d.sbit   = 64'd1 << 62;
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/complex_number_alu_top.sv -----
// Top level of the complex arithmetic unit: front end, cell chain and output register.
//
//   channel  direction  handshake                signals
//   in       input      in_valid_i / in_ready_o  cmd_i, a_re_i, a_im_i, b_re_i, b_im_i
//   out      output     out_valid_o / out_ready_i res_re_o, res_im_o, div_zero_o, overflow_o
//
// Each result passes through 37 register stages: one product stage, one
// preparation stage, a chain of 34 cells (one quotient bit each, and one root
// bit in each of the first 32) and the output register. A new item is accepted
// every cycle while the pipeline is not held.
// Reset clears only the valid bits. The whole pipeline holds while a result
// waits at the output and out_ready_i is low.
module complex_number_alu_top #(
  parameter int unsigned FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               div_zero_o,
  output logic               overflow_o
);

  localparam int unsigned QB = cna_pkg::QB;
  localparam int unsigned RW = cna_pkg::RW;

  logic           en;
  logic           ch_v [QB+1];
  cna_pkg::cell_t ch_d [QB+1];
  cna_pkg::cell_t fin;

  logic               out_valid_q;
  logic [31:0]        re_q, im_q, re_d, im_d;
  logic               dz_q, ov_q, dz_d, ov_d;

  logic               rnd_re, rnd_im, sq_up;
  logic [QB:0]        q1_re, q1_im;
  logic signed [65:0] v_re, v_im;
  logic [32:0]        s_re, s_im, root;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  cna_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .cmd_i  (cmd_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .valid_o(ch_v[0]),
    .data_o (ch_d[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_chain
    cna_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(ch_v[k]),
      .data_i (ch_d[k]),
      .valid_o(ch_v[k+1]),
      .data_o (ch_d[k+1])
    );
  end

  assign fin = ch_d[QB];

  always_comb begin
    // Round to nearest, ties away from zero, on the magnitude.
    rnd_re = {fin.rem_re, 1'b0} >= (RW+1)'(fin.den);
    rnd_im = {fin.rem_im, 1'b0} >= (RW+1)'(fin.den);
    q1_re  = (QB+1)'(fin.q_re) + (QB+1)'(rnd_re);
    q1_im  = (QB+1)'(fin.q_im) + (QB+1)'(rnd_im);
    v_re   = fin.neg_re ? -$signed(66'(q1_re)) : $signed(66'(q1_re));
    v_im   = fin.neg_im ? -$signed(66'(q1_im)) : $signed(66'(q1_im));
    s_re   = cna_pkg::sat32(v_re);
    s_im   = cna_pkg::sat32(v_im);
    if (fin.ovf_re) begin
      s_re = fin.neg_re ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end
    if (fin.ovf_im) begin
      s_im = fin.neg_im ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end

    sq_up = fin.sx > fin.sr;
    root  = 33'(fin.sr) + 33'(sq_up);

    re_d = fin.res_re;
    im_d = fin.res_im;
    ov_d = fin.ov;
    dz_d = 1'b0;
    unique case (fin.cmd)
      cna_pkg::CMD_DIV: begin
        if (fin.den == 64'd0) begin
          re_d = 32'd0;
          im_d = 32'd0;
          ov_d = 1'b0;
          dz_d = 1'b1;
        end else begin
          re_d = s_re[31:0];
          im_d = s_im[31:0];
          ov_d = s_re[32] | s_im[32];
        end
      end
      cna_pkg::CMD_MOD: begin
        if (root > 33'h0_7FFF_FFFF) begin
          re_d = 32'h7FFF_FFFF;
          ov_d = 1'b1;
        end else begin
          re_d = root[31:0];
          ov_d = 1'b0;
        end
        im_d = 32'd0;
      end
      default: begin
        re_d = fin.res_re;
        im_d = fin.res_im;
        ov_d = fin.ov;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ch_v[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q <= re_d;
      im_q <= im_d;
      dz_q <= dz_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = re_q;
  assign res_im_o    = im_q;
  assign div_zero_o  = dz_q;
  assign overflow_o  = ov_q;

endmodule
